[sv/sed_pkg.sv]
// Shared types and constants of the string escape decoder.
`default_nettype none
package sed_pkg;

  localparam logic [3:0] SHORT_RUN_DIGITS = 4'd4;
  localparam logic [3:0] LONG_RUN_DIGITS  = 4'd8;
  localparam int         MAX_GROUP        = 5;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U_LO   = 8'h75;
  localparam logic [7:0] CH_U_HI   = 8'h55;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       triple_quoted;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       empty_string;
    logic       final_result;
  } result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
    logic       no_content;
  } token_t;

  typedef struct packed {
    logic [MAX_GROUP-1:0][7:0] bytes;
    logic [2:0]                len;
    logic                      is_last;
    logic                      no_content;
  } group_t;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_X0,
    MODE_X1,
    MODE_RUN
  } mode_t;

endpackage
`default_nettype wire

[sv/string_escape_decoder_unit.sv]
// Top level of the string escape decoder.
//
// Input queue port: push a lexeme word (raw byte, triple-quote mark, last mark)
// while full is low; one word is taken per cycle. The first one or three bytes
// are stripped as the opening delimiter and the same count at the end is held
// in a delay line and dropped, so the first content byte decodes only once
// twice the delimiter length plus one words have arrived.
// Output queue port: while empty is low the oldest result byte is shown; pop
// takes it, one per cycle. The word that causes a result is registered in the
// word queue, and its bytes in the output group queue, before the result shows.
// Throughput is one word per cycle in while full is low and one byte per cycle
// out while pop is high and empty is low. A word that expands to several bytes
// (unicode escape, broken hex escape) holds the output; the word queue of
// QUEUE_DEPTH entries and a two-group output queue absorb it before full rises.
// A lexeme with no content gives one result with empty_string set.
// When pop stays low the output queue fills, the decoder stalls, then the word
// queue fills and full rises; nothing is lost.
// Synchronous reset empties both queues and returns every stage to its
// start-of-lexeme state.
`default_nettype none
module string_escape_decoder_unit #(
  parameter int MAX_DELIMITER = 3,
  parameter int QUEUE_DEPTH   = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire sed_pkg::item_t item,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output sed_pkg::result_t    result
);

  logic            tok_valid;
  sed_pkg::token_t tok;
  logic            q_valid;
  sed_pkg::token_t q_tok;
  logic            tok_take;
  logic            grp_space;
  logic            grp_valid;
  sed_pkg::group_t grp;

  sed_front #(
    .MAX_DELIMITER (MAX_DELIMITER)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .stall     (full),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  sed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (tok_valid),
    .wdata (tok),
    .rd    (tok_take),
    .full  (full),
    .valid (q_valid),
    .rdata (q_tok)
  );

  sed_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok       (q_tok),
    .grp_space (grp_space),
    .tok_take  (tok_take),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  sed_out u_out (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp       (grp),
    .pop       (pop),
    .grp_space (grp_space),
    .empty     (empty),
    .result    (result)
  );

endmodule
`default_nettype wire

[sv/sed_front.sv]
// Front end: delimiter stripping delay line and content word classification.
`default_nettype none
module sed_front #(
  parameter int MAX_DELIMITER = 3
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire sed_pkg::item_t item,
  input  wire logic           stall,
  output logic                tok_valid,
  output sed_pkg::token_t     tok
);

  localparam int SW = $clog2(2 * MAX_DELIMITER + 1);
  localparam int DI = (MAX_DELIMITER > 1) ? $clog2(MAX_DELIMITER) : 1;

  logic [SW-1:0] seen, seen_next;
  logic          triple, triple_next;
  logic [7:0]    dly [MAX_DELIMITER];
  logic [7:0]    dly_next [MAX_DELIMITER];

  logic          accept;
  logic          tq;
  logic [SW-1:0] q;
  logic [SW:0]   q2;
  logic          in_head;
  logic          in_fill;
  logic          release_byte;
  logic [DI-1:0] fidx;
  logic [DI-1:0] qm1;
  logic [SW-1:0] diff;
  logic [SW-1:0] qdec;

  assign accept       = push && !stall;
  assign tq           = (seen == '0) ? item.triple_quoted : triple;
  assign q            = tq ? SW'(MAX_DELIMITER) : SW'(1);
  assign q2           = {q, 1'b0};
  assign in_head      = seen < q;
  assign in_fill      = !in_head && ({1'b0, seen} < q2);
  assign release_byte = !in_head && !in_fill;
  assign diff         = seen - q;
  assign qdec         = q - SW'(1);
  assign fidx         = diff[DI-1:0];
  assign qm1          = qdec[DI-1:0];

  always_comb begin
    seen_next   = seen;
    triple_next = triple;
    if (accept) begin
      if (item.last_byte) begin
        seen_next   = '0;
        triple_next = 1'b0;
      end else begin
        triple_next = tq;
        if (!release_byte) begin
          seen_next = seen + SW'(1);
        end
      end
    end
  end

  always_comb begin
    dly_next = dly;
    if (accept && in_fill) begin
      dly_next[fidx] = item.raw_byte;
    end
    if (accept && release_byte) begin
      for (int i = 0; i < MAX_DELIMITER - 1; i++) begin
        if (SW'(i + 1) < q) begin
          dly_next[i] = dly[i + 1];
        end
      end
      dly_next[qm1] = item.raw_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= '0;
      triple <= 1'b0;
    end else begin
      seen   <= seen_next;
      triple <= triple_next;
    end
    dly <= dly_next;
  end

  assign tok_valid      = accept && (release_byte || item.last_byte);
  assign tok.data       = dly[0];
  assign tok.is_last    = item.last_byte;
  assign tok.no_content = !release_byte;

endmodule
`default_nettype wire

[sv/sed_queue.sv]
// Word queue between the front end and the decoder.
`default_nettype none
module sed_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire sed_pkg::token_t wdata,
  input  wire logic            rd,
  output logic                 full,
  output logic                 valid,
  output sed_pkg::token_t      rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sed_pkg::token_t mem [DEPTH];
  logic [PW-1:0]   wp, rp;
  logic [CW-1:0]   cnt;

  assign full  = cnt == CW'(DEPTH);
  assign valid = cnt != '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (rd) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      cnt <= cnt + CW'(wr) - CW'(rd);
    end
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

endmodule
`default_nettype wire

[sv/sed_back.sv]
// Decoder: escape state machine turning one content word into a group of bytes.
`default_nettype none
module sed_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            tok_valid,
  input  wire sed_pkg::token_t tok,
  input  wire logic            grp_space,
  output logic                 tok_take,
  output logic                 grp_valid,
  output sed_pkg::group_t      grp
);

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } utf8_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [8:0] simple_val(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      "n":       r = {1'b1, 8'h0A};
      "t":       r = {1'b1, 8'h09};
      "r":       r = {1'b1, 8'h0D};
      "0":       r = {1'b1, 8'h00};
      "a":       r = {1'b1, 8'h07};
      "b":       r = {1'b1, 8'h08};
      "f":       r = {1'b1, 8'h0C};
      "v":       r = {1'b1, 8'h0B};
      8'h5C:     r = {1'b1, 8'h5C};
      8'h22:     r = {1'b1, 8'h22};
      8'h27:     r = {1'b1, 8'h27};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [31:0] cp);
    utf8_t u;
    u = '0;
    if (cp < 32'h80) begin
      u.b[0] = cp[7:0];
      u.len  = 3'd1;
    end else if (cp < 32'h800) begin
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
      u.len  = 3'd2;
    end else if (cp < 32'h10000) begin
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
      u.len  = 3'd3;
    end else if (cp <= 32'h10FFFF) begin
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
      u.len  = 3'd4;
    end else begin
      u.b[0] = 8'hEF;
      u.b[1] = 8'hBF;
      u.b[2] = 8'hBD;
      u.len  = 3'd3;
    end
    return u;
  endfunction

  sed_pkg::mode_t mode, mode_next, dec_mode;
  logic [7:0]     held, held_next, dec_held;
  logic [31:0]    acc, acc_next, dec_acc;
  logic [3:0]     cnt, cnt_next, dec_cnt;
  logic           lflag, lflag_next, dec_lflag;

  logic [7:0]     c;
  logic           fin;
  logic [4:0]     hx;
  logic [4:0]     hh;
  logic [8:0]     sv;
  logic [3:0]     width;
  logic           run_take;
  logic           run_done;
  logic           plain_esc;
  sed_pkg::mode_t nb_mode;
  utf8_t          u;

  logic [sed_pkg::MAX_GROUP-1:0][7:0] bts;
  logic [2:0]                         n;

  assign c         = tok.data;
  assign fin       = tok.is_last;
  assign hx        = hex_val(c);
  assign hh        = hex_val(held);
  assign sv        = simple_val(c);
  assign width     = lflag ? sed_pkg::LONG_RUN_DIGITS : sed_pkg::SHORT_RUN_DIGITS;
  assign run_take  = hx[4] && (cnt < width);
  assign run_done  = run_take && ((cnt + 4'd1) >= width);
  assign plain_esc = (c == sed_pkg::CH_BSLASH) && !fin;
  assign nb_mode   = plain_esc ? sed_pkg::MODE_ESC : sed_pkg::MODE_NORMAL;
  assign tok_take  = tok_valid && grp_space;
  assign u         = utf8_enc(dec_acc);

  always_comb begin
    dec_mode  = mode;
    dec_held  = held;
    dec_acc   = acc;
    dec_cnt   = cnt;
    dec_lflag = lflag;
    if (!tok.no_content) begin
      unique case (mode)
        sed_pkg::MODE_ESC: begin
          dec_mode = sed_pkg::MODE_NORMAL;
          if (!sv[8] && c == sed_pkg::CH_X) begin
            dec_mode = sed_pkg::MODE_X0;
          end else if (!sv[8] && (c == sed_pkg::CH_U_LO || c == sed_pkg::CH_U_HI)) begin
            dec_mode  = sed_pkg::MODE_RUN;
            dec_lflag = c == sed_pkg::CH_U_HI;
            dec_acc   = '0;
            dec_cnt   = '0;
          end
        end
        sed_pkg::MODE_X0: begin
          if (hx[4]) begin
            dec_held = c;
            dec_mode = sed_pkg::MODE_X1;
          end else begin
            dec_mode = nb_mode;
          end
        end
        sed_pkg::MODE_X1: begin
          dec_mode = hx[4] ? sed_pkg::MODE_NORMAL : nb_mode;
        end
        sed_pkg::MODE_RUN: begin
          if (run_take) begin
            dec_acc = {acc[27:0], hx[3:0]};
            dec_cnt = cnt + 4'd1;
            if (run_done) begin
              dec_mode = sed_pkg::MODE_NORMAL;
            end
          end else begin
            dec_mode = nb_mode;
          end
        end
        sed_pkg::MODE_NORMAL: begin
          dec_mode = nb_mode;
        end
        default: begin
          dec_mode = nb_mode;
        end
      endcase
    end
  end

  always_comb begin
    mode_next  = dec_mode;
    held_next  = dec_held;
    acc_next   = dec_acc;
    cnt_next   = dec_cnt;
    lflag_next = dec_lflag;
    if (fin) begin
      mode_next  = sed_pkg::MODE_NORMAL;
      held_next  = '0;
      acc_next   = '0;
      cnt_next   = '0;
      lflag_next = 1'b0;
    end
  end

  always_comb begin
    bts = '0;
    n   = 3'd0;
    if (tok.no_content) begin
      n = 3'd1;
    end else begin
      unique case (mode)
        sed_pkg::MODE_ESC: begin
          if (sv[8]) begin
            bts[n] = sv[7:0];
            n      = n + 3'd1;
          end else if (c != sed_pkg::CH_X && c != sed_pkg::CH_U_LO
                       && c != sed_pkg::CH_U_HI) begin
            bts[n] = c;
            n      = n + 3'd1;
          end
        end
        sed_pkg::MODE_X0: begin
          if (!hx[4]) begin
            bts[n] = sed_pkg::CH_X;
            n      = n + 3'd1;
            if (!plain_esc) begin
              bts[n] = c;
              n      = n + 3'd1;
            end
          end
        end
        sed_pkg::MODE_X1: begin
          if (hx[4]) begin
            bts[n] = {hh[3:0], hx[3:0]};
            n      = n + 3'd1;
          end else begin
            bts[n] = sed_pkg::CH_X;
            n      = n + 3'd1;
            bts[n] = held;
            n      = n + 3'd1;
            if (!plain_esc) begin
              bts[n] = c;
              n      = n + 3'd1;
            end
          end
        end
        sed_pkg::MODE_RUN: begin
          if (!run_take || run_done) begin
            for (int k = 0; k < 4; k++) begin
              if (3'(k) < u.len) begin
                bts[n] = u.b[k];
                n      = n + 3'd1;
              end
            end
          end
          if (!run_take && !plain_esc) begin
            bts[n] = c;
            n      = n + 3'd1;
          end
        end
        sed_pkg::MODE_NORMAL: begin
          if (!plain_esc) begin
            bts[n] = c;
            n      = n + 3'd1;
          end
        end
        default: begin
          if (!plain_esc) begin
            bts[n] = c;
            n      = n + 3'd1;
          end
        end
      endcase
      if (fin) begin
        unique case (dec_mode)
          sed_pkg::MODE_X0: begin
            bts[n] = sed_pkg::CH_X;
            n      = n + 3'd1;
          end
          sed_pkg::MODE_X1: begin
            bts[n] = sed_pkg::CH_X;
            n      = n + 3'd1;
            bts[n] = dec_held;
            n      = n + 3'd1;
          end
          sed_pkg::MODE_RUN: begin
            for (int k = 0; k < 4; k++) begin
              if (3'(k) < u.len) begin
                bts[n] = u.b[k];
                n      = n + 3'd1;
              end
            end
          end
          sed_pkg::MODE_ESC: begin
            bts[n] = sed_pkg::CH_BSLASH;
            n      = n + 3'd1;
          end
          sed_pkg::MODE_NORMAL: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign grp_valid      = tok_take && (n != 3'd0);
  assign grp.bytes      = bts;
  assign grp.len        = n;
  assign grp.is_last    = fin;
  assign grp.no_content = tok.no_content;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= sed_pkg::MODE_NORMAL;
      held  <= '0;
      acc   <= '0;
      cnt   <= '0;
      lflag <= 1'b0;
    end else if (tok_take) begin
      mode  <= mode_next;
      held  <= held_next;
      acc   <= acc_next;
      cnt   <= cnt_next;
      lflag <= lflag_next;
    end
  end

endmodule
`default_nettype wire

[sv/sed_out.sv]
// Output side: two-slot group queue and byte serialiser.
`default_nettype none
module sed_out (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            grp_valid,
  input  wire sed_pkg::group_t grp,
  input  wire logic            pop,
  output logic                 grp_space,
  output logic                 empty,
  output sed_pkg::result_t     result
);

  sed_pkg::group_t slot [2];
  logic            wp, rp;
  logic [1:0]      gcnt;
  logic [2:0]      idx;
  sed_pkg::group_t head;
  logic            at_end;
  logic            take;
  logic            done;

  assign head      = slot[rp];
  assign grp_space = gcnt != 2'd2;
  assign empty     = gcnt == 2'd0;
  assign at_end    = idx == (head.len - 3'd1);
  assign take      = pop && !empty;
  assign done      = take && at_end;

  assign result.out_byte     = head.bytes[idx];
  assign result.empty_string = head.no_content;
  assign result.final_result = head.is_last && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      gcnt <= 2'd0;
      idx  <= 3'd0;
    end else begin
      if (grp_valid) begin
        wp <= ~wp;
      end
      if (done) begin
        rp  <= ~rp;
        idx <= 3'd0;
      end else if (take) begin
        idx <= idx + 3'd1;
      end
      gcnt <= gcnt + 2'(grp_valid) - 2'(done);
    end
    if (grp_valid) begin
      slot[wp] <= grp;
    end
  end

endmodule
`default_nettype wire

[tb/string_escape_decoder_unit_test.sv]
// Testbench of the string escape decoder unit: decode scoreboard, word drivers and checks.
module string_escape_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DELIM = 3;
  localparam int LONG_HOLD = 60;
  localparam int PHASE_WORDS = 85;
  localparam int SETTLE_CYCLES = 20;

  typedef logic [7:0] octet_t;

  class escape_scoreboard;
    sed_pkg::result_t decoded_q[$];
    int errors;
    octet_t delay_line[3];
    int seen;
    bit triple;
    sed_pkg::mode_t mode;
    octet_t held_digit;
    logic [31:0] code_acc;
    int digits;
    bit long_run;
    int step_count;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      foreach (delay_line[i]) delay_line[i] = '0;
      seen = 0;
      triple = 0;
      mode = sed_pkg::MODE_NORMAL;
      held_digit = '0;
      code_acc = '0;
      digits = 0;
      long_run = 0;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function int pending();
      return decoded_q.size();
    endfunction

    function int hex_value(octet_t c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    function int simple_value(octet_t c);
      case (c)
        "n": return 'h0A;
        "t": return 'h09;
        "r": return 'h0D;
        "0": return 'h00;
        "a": return 'h07;
        "b": return 'h08;
        "f": return 'h0C;
        "v": return 'h0B;
        sed_pkg::CH_BSLASH: return int'(sed_pkg::CH_BSLASH);
        "\"": return 'h22;
        "'": return 'h27;
        default: return -1;
      endcase
    endfunction

    function void emit(octet_t b);
      sed_pkg::result_t r;
      if (step_count < sed_pkg::MAX_GROUP) begin
        r.out_byte = b;
        r.empty_string = 1'b0;
        r.final_result = 1'b0;
        decoded_q.push_back(r);
        step_count++;
      end
    endfunction

    function void emit_code(logic [31:0] cp);
      if (cp < 32'h80) begin
        emit(cp[7:0]);
      end else if (cp < 32'h800) begin
        emit({3'b110, cp[10:6]});
        emit({2'b10, cp[5:0]});
      end else if (cp < 32'h10000) begin
        emit({4'b1110, cp[15:12]});
        emit({2'b10, cp[11:6]});
        emit({2'b10, cp[5:0]});
      end else if (cp <= 32'h10FFFF) begin
        emit({5'b11110, cp[20:18]});
        emit({2'b10, cp[17:12]});
        emit({2'b10, cp[11:6]});
        emit({2'b10, cp[5:0]});
      end else begin
        emit(8'hEF);
        emit(8'hBF);
        emit(8'hBD);
      end
    endfunction

    function void plain(octet_t c, bit fin);
      if (c == sed_pkg::CH_BSLASH && !fin) mode = sed_pkg::MODE_ESC;
      else emit(c);
    endfunction

    function void decode(octet_t c, bit fin);
      int d;
      int s;
      int width;
      d = hex_value(c);
      case (mode)
        sed_pkg::MODE_ESC: begin
          s = simple_value(c);
          mode = sed_pkg::MODE_NORMAL;
          if (s >= 0) begin
            emit(8'(s));
          end else if (c == sed_pkg::CH_X) begin
            mode = sed_pkg::MODE_X0;
          end else if (c == sed_pkg::CH_U_LO || c == sed_pkg::CH_U_HI) begin
            mode = sed_pkg::MODE_RUN;
            long_run = (c == sed_pkg::CH_U_HI);
            code_acc = '0;
            digits = 0;
          end else begin
            emit(c);
          end
        end
        sed_pkg::MODE_X0: begin
          if (d >= 0) begin
            held_digit = c;
            mode = sed_pkg::MODE_X1;
          end else begin
            emit(sed_pkg::CH_X);
            mode = sed_pkg::MODE_NORMAL;
            plain(c, fin);
          end
        end
        sed_pkg::MODE_X1: begin
          mode = sed_pkg::MODE_NORMAL;
          if (d >= 0) begin
            emit(8'((hex_value(held_digit) << 4) | d));
          end else begin
            emit(sed_pkg::CH_X);
            emit(held_digit);
            plain(c, fin);
          end
        end
        sed_pkg::MODE_RUN: begin
          width = long_run ? int'(sed_pkg::LONG_RUN_DIGITS)
                           : int'(sed_pkg::SHORT_RUN_DIGITS);
          if (d >= 0 && digits < width) begin
            code_acc = {code_acc[27:0], 4'(d)};
            digits++;
            if (digits >= width) begin
              emit_code(code_acc);
              mode = sed_pkg::MODE_NORMAL;
            end
          end else begin
            emit_code(code_acc);
            mode = sed_pkg::MODE_NORMAL;
            plain(c, fin);
          end
        end
        default: begin
          mode = sed_pkg::MODE_NORMAL;
          plain(c, fin);
        end
      endcase
    endfunction

    function void flush();
      case (mode)
        sed_pkg::MODE_X0: emit(sed_pkg::CH_X);
        sed_pkg::MODE_X1: begin
          emit(sed_pkg::CH_X);
          emit(held_digit);
        end
        sed_pkg::MODE_RUN: emit_code(code_acc);
        sed_pkg::MODE_ESC: emit(sed_pkg::CH_BSLASH);
        default: ;
      endcase
      mode = sed_pkg::MODE_NORMAL;
    endfunction

    function void note_word(sed_pkg::item_t w);
      octet_t rel;
      bit released;
      int q;
      sed_pkg::result_t blank;
      step_count = 0;
      released = 0;
      rel = '0;
      if (seen == 0) triple = w.triple_quoted;
      q = triple ? MAX_DELIM : 1;
      if (seen < q) begin
        seen++;
      end else if (seen < 2 * q) begin
        delay_line[(seen - q) % 3] = w.raw_byte;
        seen++;
      end else begin
        rel = delay_line[0];
        released = 1;
        for (int i = 0; i + 1 < q; i++) delay_line[i] = delay_line[i + 1];
        delay_line[(q - 1) % 3] = w.raw_byte;
      end
      if (released) decode(rel, w.last_byte);
      if (w.last_byte) begin
        if (!released) begin
          blank.out_byte = '0;
          blank.empty_string = 1'b1;
          blank.final_result = 1'b1;
          decoded_q.push_back(blank);
        end else begin
          flush();
          if (step_count > 0) decoded_q[decoded_q.size() - 1].final_result = 1'b1;
        end
        clear();
      end
    endfunction

    task check_result(sed_pkg::result_t r);
      sed_pkg::result_t e;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected word %h", r));
        return;
      end
      e = decoded_q.pop_front();
      if (r.out_byte !== e.out_byte)
        report($sformatf("out_byte %h, want %h", r.out_byte, e.out_byte));
      if (r.empty_string !== e.empty_string)
        report($sformatf("empty_string %b, want %b", r.empty_string, e.empty_string));
      if (r.final_result !== e.final_result)
        report($sformatf("final_result %b, want %b", r.final_result, e.final_result));
    endtask
  endclass

  logic clk;
  logic rst;
  logic push;
  sed_pkg::item_t in_word;
  logic full;
  logic pop;
  logic empty;
  sed_pkg::result_t out_word;

  escape_scoreboard sb;
  octet_t lexeme[$];
  int send_idle_pct;
  int recv_stall_pct;
  int phase_words;
  int hold_asks;
  int hold_seen;
  int hold_left;
  string hex_chars = "0123456789abcdefABCDEF";
  string simple_chars = "ntr0abfv\\\"'";

  string_escape_decoder_unit #(
    .MAX_DELIMITER(MAX_DELIM)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(in_word),
    .full(full),
    .pop(pop),
    .empty(empty),
    .result(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    pop = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD - 1;
        pop <= 1'b0;
      end else begin
        pop <= !rst && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(out_word);
  end

  task automatic send_word(sed_pkg::item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (full);
    sb.note_word(w);
    phase_words++;
    @(negedge clk);
  endtask

  task automatic send_lexeme(bit triple, bit noisy);
    sed_pkg::item_t w;
    for (int i = 0; i < lexeme.size(); i++) begin
      w.raw_byte = lexeme[i];
      w.triple_quoted = (i == 0 && !noisy) ? triple : 1'($urandom_range(1));
      w.last_byte = (i == lexeme.size() - 1);
      send_word(w);
    end
  endtask

  task automatic load_text(string s);
    lexeme.delete();
    for (int i = 0; i < s.len(); i++) lexeme.push_back(s[i]);
  endtask

  task automatic add_hex(int n);
    for (int i = 0; i < n; i++) lexeme.push_back(hex_chars[$urandom_range(21)]);
  endtask

  task automatic add_element();
    octet_t c;
    case ($urandom_range(9))
      0, 1: begin
        c = 8'($urandom_range(32, 126));
        lexeme.push_back(c == sed_pkg::CH_BSLASH ? 8'h61 : c);
      end
      2: lexeme.push_back(8'($urandom_range(255)));
      3: begin
        lexeme.push_back(sed_pkg::CH_BSLASH);
        lexeme.push_back(simple_chars[$urandom_range(simple_chars.len() - 1)]);
      end
      4: begin
        lexeme.push_back(sed_pkg::CH_BSLASH);
        lexeme.push_back(sed_pkg::CH_X);
        add_hex(2);
      end
      5: begin
        lexeme.push_back(sed_pkg::CH_BSLASH);
        lexeme.push_back(sed_pkg::CH_X);
        add_hex($urandom_range(1));
      end
      6: begin
        lexeme.push_back(sed_pkg::CH_BSLASH);
        lexeme.push_back(sed_pkg::CH_U_LO);
        add_hex($urandom_range(5));
      end
      7: begin
        lexeme.push_back(sed_pkg::CH_BSLASH);
        lexeme.push_back(sed_pkg::CH_U_HI);
        add_hex($urandom_range(3) == 0 ? $urandom_range(5) : $urandom_range(6, 9));
      end
      8: begin
        lexeme.push_back(sed_pkg::CH_BSLASH);
        lexeme.push_back(8'($urandom_range(255)));
      end
      default: lexeme.push_back(sed_pkg::CH_BSLASH);
    endcase
  endtask

  task automatic add_delimiter(int q);
    for (int i = 0; i < q; i++)
      lexeme.push_back($urandom_range(9) == 0 ? 8'($urandom_range(255)) : 8'h22);
  endtask

  task automatic send_random_lexeme();
    bit triple;
    int q;
    int n;
    lexeme.delete();
    if ($urandom_range(99) < 80) begin
      triple = ($urandom_range(99) < 30);
      q = triple ? MAX_DELIM : 1;
      add_delimiter(q);
      n = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 5);
      for (int i = 0; i < n; i++) add_element();
      add_delimiter(q);
      send_lexeme(triple, 1'b0);
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) lexeme.push_back(8'($urandom_range(255)));
      send_lexeme(1'b0, 1'b1);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    in_word = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_asks = 0;
    phase_words = 0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 47; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 47; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      if (ph == 0) begin
        load_text("\"\"");
        send_lexeme(1'b0, 1'b0);
        load_text("\"\\x4\\q\"");
        send_lexeme(1'b0, 1'b0);
        load_text("\"\\U110000\\u\"");
        send_lexeme(1'b0, 1'b0);
        load_text("\"\"\"\\\"\"\"");
        send_lexeme(1'b1, 1'b0);
        hold_asks++;
      end
      if (ph == 2) hold_asks++;
      phase_words = 0;
      while (phase_words < PHASE_WORDS) send_random_lexeme();
      drain();
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
